// ===== hw/rtl/ipd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared constants for the isolated pixel detector: register widths, register
// indexes, reset values and default frame limits.
// ----------------------------------------------------------------------------
package ipd_pkg;

   localparam int FRAME_ROWS_W = 13;
   localparam int FRAME_COLS_W = 11;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_ROWS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_COLS = 1'd1;

   localparam logic [FRAME_ROWS_W-1:0] FRAME_ROWS_RST = 13'd4096;
   localparam logic [FRAME_COLS_W-1:0] FRAME_COLS_RST = 11'd1024;

   localparam int DEF_MAX_COLS = 1024;
   localparam int DEF_MAX_ROWS = 4096;

   localparam int LINE_W = 2;

endpackage

// ===== hw/rtl/ipd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_if
// Valid/ready channels of the isolated pixel detector: pixel words in,
// per-frame result words out.
// ----------------------------------------------------------------------------
interface ipd_req_if;
   logic valid;
   logic ready;
   logic pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface ipd_rsp_if;
   logic valid;
   logic ready;
   logic isolated_found;

   modport source (output valid, output isolated_found, input ready);
   modport sink   (input valid, input isolated_found, output ready);
endinterface

// ===== hw/rtl/ipd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_ram
// Simple dual-port RAM: one write port, one read port with registered,
// read-first data that holds while no read is issued.
// ----------------------------------------------------------------------------
module ipd_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/isolated_pixel_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isolated_pixel_detector
// Finds, per binary frame, any interior set pixel whose left, right, upper and lower
// neighbors are all clear, and reports a result word when each frame ends.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock in raster order while no waiting result
// holds the check stage; the rate is set by the line-store RAM, which is read
// once for each accepted pixel and written once as each pixel is checked. A
// pixel is registered together with its line-store read, then checked and
// written back as the check stage advances; at the frame's last pixel that
// also loads the frame result into the output register. A waiting result
// blocks input only when the next frame ends before it is taken. Frame size
// is set by frame_rows (index 0) and frame_cols (index 1); 0 acts as 1 and
// values above the build limits saturate. Frames with fewer than 3 rows or
// columns report 0. The line store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module isolated_pixel_detector #(
   parameter int MAX_COLS = ipd_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = ipd_pkg::DEF_MAX_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   ipd_req_if.sink                         req_ch,
   ipd_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [ipd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ipd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import ipd_pkg::*;

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int CCW   = (FRAME_COLS_W > $clog2(MAX_COLS + 1)) ?
                          FRAME_COLS_W : $clog2(MAX_COLS + 1);
   localparam int RCW   = (FRAME_ROWS_W > $clog2(MAX_ROWS + 1)) ?
                          FRAME_ROWS_W : $clog2(MAX_ROWS + 1);

   // configuration
   logic [FRAME_ROWS_W-1:0] rows_cfg_ff;
   logic [FRAME_COLS_W-1:0] cols_cfg_ff;
   logic [RCW-1:0]          rows_eff;
   logic [CCW-1:0]          cols_eff;

   // position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             last_col, last_row;

   // check stage
   logic             s1_valid_ff;
   logic             s1_pixel_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_chk_ff;
   logic             s1_last_ff;
   logic             s1_go;
   logic             fwd_ff;
   logic [LINE_W-1:0] fwd_data_ff;

   // window taps and flag
   logic [1:0] mid_ff;
   logic       top_ff;
   logic       cur_ff;
   logic       match_ff, match_in;

   // line store
   logic [LINE_W-1:0] ram_rdata;
   logic [LINE_W-1:0] stored;
   logic [LINE_W-1:0] wr_data;
   logic              prev1, prev2;
   logic              hit;

   // result
   logic rsp_valid_ff;
   logic rsp_found_ff;

   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= FRAME_ROWS_RST;
         cols_cfg_ff <= FRAME_COLS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_ROWS: rows_cfg_ff <= csr_wdata[FRAME_ROWS_W-1:0];
            CSR_FRAME_COLS: cols_cfg_ff <= csr_wdata[FRAME_COLS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (rows_cfg_ff == '0) begin
         rows_eff = RCW'(1);
      end else if (RCW'(rows_cfg_ff) > RCW'(MAX_ROWS)) begin
         rows_eff = RCW'(MAX_ROWS);
      end else begin
         rows_eff = RCW'(rows_cfg_ff);
      end
      if (cols_cfg_ff == '0) begin
         cols_eff = CCW'(1);
      end else if (CCW'(cols_cfg_ff) > CCW'(MAX_COLS)) begin
         cols_eff = CCW'(MAX_COLS);
      end else begin
         cols_eff = CCW'(cols_cfg_ff);
      end
   end

   // advance the check stage unless it ends a frame while the result is held
   assign s1_go  = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign accept = req_ch.valid && req_ch.ready;

   assign last_col = (CCW'(col_ff) + CCW'(1)) >= cols_eff;
   assign last_row = (RCW'(row_ff) + RCW'(1)) >= rows_eff;

   always_comb begin
      col_in = col_ff + COL_W'(1);
      row_in = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
            fwd_ff <= s1_go && (s1_col_ff == col_ff);
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_ch.pixel;
         s1_col_ff   <= col_ff;
         s1_chk_ff   <= (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
         s1_last_ff  <= last_col && last_row;
         fwd_data_ff <= wr_data;
      end
   end

   ipd_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_COLS)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rdata)
   );

   assign stored  = fwd_ff ? fwd_data_ff : ram_rdata;
   assign prev1   = stored[0];
   assign prev2   = stored[1];
   assign wr_data = {prev1, s1_pixel_ff};

   assign hit      = s1_chk_ff && mid_ff[0] && !mid_ff[1] && !prev1 && !top_ff && !cur_ff;
   assign match_in = match_ff || hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff   <= '0;
         top_ff   <= 1'b0;
         cur_ff   <= 1'b0;
         match_ff <= 1'b0;
      end else if (s1_go) begin
         if (s1_last_ff) begin
            mid_ff   <= '0;
            top_ff   <= 1'b0;
            cur_ff   <= 1'b0;
            match_ff <= 1'b0;
         end else begin
            mid_ff   <= {mid_ff[0], prev1};
            top_ff   <= prev2;
            cur_ff   <= s1_pixel_ff;
            match_ff <= match_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_last_ff) begin
         rsp_found_ff <= match_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.isolated_found = rsp_found_ff;

   a_result_follows_frame_end : assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff) |=> rsp_valid_ff)
      else $error("frame end did not load the result register");

   a_frame_state_cleared : assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff) |=> (!match_ff && mid_ff == '0 && !top_ff && !cur_ff))
      else $error("window state not cleared at frame end");

   a_forward_only_column_zero : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && fwd_ff) |-> (s1_col_ff == '0))
      else $error("line-store bypass used away from column zero");

   a_no_accept_on_stall : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |-> !req_ch.ready)
      else $error("word accepted while check stage is held");

   a_col_in_range : assert property (@(posedge clock) disable iff (reset)
      (CCW'(col_ff) < CCW'(MAX_COLS)))
      else $error("column counter beyond line store");

endmodule

// ===== sim/isolated_pixel_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isolated_pixel_detector_tb
// Streams binary frames through the detector and checks each end-of-frame
// word against a cycle-free model of the line store, window taps and sticky
// flag. Covers hand-made 3x3 shapes, zero and clamped frame sizes, the widest
// frame, a resize in the middle of a frame and at least 900 random pixels
// over small random sizes and densities, with random stalls on both channels
// in the first two of three phases.
// ----------------------------------------------------------------------------
module isolated_pixel_detector_tb;
   import ipd_pkg::*;

   localparam int          CLOCK_PERIOD  = 12;
   localparam int          RESET_CYCLES  = 6;
   localparam int          SETTLE_CYCLES = 6;
   localparam int          STALL_LIMIT   = 2000;
   localparam int unsigned RANDOM_PIXELS = 900;
   localparam int          REPORT_LIMIT  = 10;

   // center alone, center with diagonal corners, center with the pixel above
   localparam logic [8:0] SHAPES [3] = '{9'b000_010_000, 9'b101_010_101, 9'b010_010_000};

   class isolation_tracker;
      logic [FRAME_ROWS_W-1:0] rows_reg;
      logic [FRAME_COLS_W-1:0] cols_reg;
      logic [1:0]              history [DEF_MAX_COLS];
      logic [1:0]              mid_taps;
      logic                    top_tap;
      logic                    cur_tap;
      logic                    found;
      int unsigned             row_pos;
      int unsigned             col_pos;
      logic                    verdict_q [$];
      int unsigned             mismatches;
      int unsigned             frames;
      int unsigned             hits;
      int unsigned             pixels;

      function new();
         rows_reg = FRAME_ROWS_RST;
         cols_reg = FRAME_COLS_RST;
         foreach (history[i]) history[i] = 2'b00;
         clear_frame();
         mismatches = 0;
         frames     = 0;
         hits       = 0;
         pixels     = 0;
      endfunction

      function void clear_frame();
         mid_taps = 2'b00;
         top_tap  = 1'b0;
         cur_tap  = 1'b0;
         found    = 1'b0;
         row_pos  = 0;
         col_pos  = 0;
      endfunction

      function int unsigned clamp_dim(int unsigned value, int unsigned limit);
         if (value == 0) return 1;
         if (value > limit) return limit;
         return value;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_FRAME_ROWS: rows_reg = value[FRAME_ROWS_W-1:0];
            CSR_FRAME_COLS: cols_reg = value[FRAME_COLS_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_pixel(logic px);
         int unsigned rows;
         int unsigned cols;
         int unsigned col;
         logic [1:0]  above;
         rows  = clamp_dim(rows_reg, DEF_MAX_ROWS);
         cols  = clamp_dim(cols_reg, DEF_MAX_COLS);
         col   = (col_pos >= DEF_MAX_COLS) ? DEF_MAX_COLS - 1 : col_pos;
         above = history[col];
         if (row_pos >= 2 && col >= 2 && mid_taps == 2'b01 && !above[0] && !top_tap && !cur_tap)
            found = 1'b1;
         mid_taps     = {mid_taps[0], above[0]};
         top_tap      = above[1];
         cur_tap      = px;
         history[col] = {above[0], px};
         pixels++;
         if (col + 1 >= cols && row_pos + 1 >= rows) begin
            verdict_q.push_back(found);
            clear_frame();
         end else if (col + 1 >= cols) begin
            col_pos = 0;
            row_pos++;
         end else begin
            col_pos = col + 1;
         end
      endfunction

      function void check_verdict(logic got);
         logic want;
         if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result word: isolated_found=%0b", got);
         end else begin
            want = verdict_q.pop_front();
            frames++;
            if (want) hits++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("frame %0d: isolated_found expected %0b, got %0b", frames, want, got);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int unsigned            send_idle_pct = 0;
   int unsigned            recv_idle_pct = 0;
   int                     quiet_cycles  = 0;
   isolation_tracker       sb;

   ipd_req_if req_ch();
   ipd_rsp_if rsp_ch();

   isolated_pixel_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_pixel(req_ch.pixel);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_verdict(rsp_ch.isolated_found);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("isolated_pixel_detector_tb: FAIL");
      $finish;
   end

   task automatic send_pixel(input logic px);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel <= px;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_frame(input int unsigned density, output int unsigned count);
      count = sb.clamp_dim(sb.rows_reg, DEF_MAX_ROWS) * sb.clamp_dim(sb.cols_reg, DEF_MAX_COLS);
      repeat (count) send_pixel($urandom_range(0, 99) < density);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (sb.verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame_size(input int unsigned rows, input int unsigned cols);
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_ROWS;
      csr_wdata <= CSR_DATA_W'(rows);
      @(posedge clock);
      csr_index <= CSR_FRAME_COLS;
      csr_wdata <= CSR_DATA_W'(cols);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(CSR_FRAME_ROWS, CSR_DATA_W'(rows));
      sb.write_reg(CSR_FRAME_COLS, CSR_DATA_W'(cols));
   endtask

   function automatic int unsigned pick_dim();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return $urandom_range(0, 2);
      if (roll == 1) return $urandom_range(9, 16);
      return $urandom_range(3, 8);
   endfunction

   initial begin
      int unsigned random_pixels;
      int unsigned density;
      int unsigned count;
      logic        resize;
      random_pixels = 0;
      sb = new();
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.pixel <= 1'b0;
      csr_we       <= 1'b0;
      csr_index    <= CSR_FRAME_ROWS;
      csr_wdata    <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 46 : 0;
         recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 30 : 0;
         case (phase)
            0: begin
               set_frame_size(3, 3);
               foreach (SHAPES[k])
                  for (int i = 8; i >= 0; i--) send_pixel(SHAPES[k][i]);
               drain_results();
               set_frame_size(0, 0);
               send_pixel(1'b1);
               send_pixel(1'b0);
            end
            1: begin
               // shrink both sizes with the counters past the new last position
               drain_results();
               set_frame_size(6, 8);
               send_frame(20, count);
               repeat (21) send_pixel($urandom_range(0, 99) < 30);
               drain_results();
               set_frame_size(2, 3);
               send_pixel($urandom_range(0, 1));
            end
            default: begin
               drain_results();
               set_frame_size(0, 2047);
               send_frame(50, count);
            end
         endcase
         resize = 1'b1;
         while (random_pixels < (phase + 1) * RANDOM_PIXELS / 3) begin
            if (resize || $urandom_range(0, 3) == 0) begin
               drain_results();
               set_frame_size(pick_dim(), pick_dim());
            end
            resize = 1'b0;
            case ($urandom_range(0, 3))
               0:       density = 5;
               1:       density = 20;
               2:       density = 50;
               default: density = 85;
            endcase
            send_frame(density, count);
            random_pixels += count;
         end
      end

      drain_results();
      $display("isolated_pixel_detector_tb: %0d pixels, %0d frames checked, %0d with a hit",
               sb.pixels, sb.frames, sb.hits);
      $display("isolated_pixel_detector_tb: 3x3 shapes, zero and clamped sizes, resize mid-frame");
      if (sb.mismatches == 0 && sb.verdict_q.size() == 0) begin
         $display("isolated_pixel_detector_tb: PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.verdict_q.size());
         $display("isolated_pixel_detector_tb: FAIL");
      end
      $finish;
   end

endmodule
